// ===== hdl/mcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcdc_pkg
// Shared constants and types for the multichannel DC-removal filter.
// ----------------------------------------------------------------------------
package mcdc_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 24;
  localparam int VALUE_W  = 16;
  localparam int BASE_W   = 32;
  localparam int REC_W    = 15;
  localparam int CFG_W    = 32;

  // per-channel memory word: {recovery counter, baseline}
  localparam int WORD_W = REC_W + BASE_W;

  typedef enum logic [2:0] {
    REG_INIT_COUNT     = 3'd0,
    REG_FAST_BETA      = 3'd1,
    REG_SLOW_BETA      = 3'd2,
    REG_NOISE_SHIFT    = 3'd3,
    REG_JUMP_LEVEL     = 3'd4,
    REG_RECOVERY_COUNT = 3'd5,
    REG_OUT_MAX        = 3'd6,
    REG_OUT_MIN        = 3'd7
  } reg_index_t;

  localparam logic [14:0] INIT_COUNT_RST     = 15'd16;
  localparam logic [31:0] FAST_BETA_RST      = 32'd67108864;
  localparam logic [31:0] SLOW_BETA_RST      = 32'd1048576;
  localparam logic [4:0]  NOISE_SHIFT_RST    = 5'd0;
  localparam logic [30:0] JUMP_LEVEL_RST     = 31'd30000;
  localparam logic [14:0] RECOVERY_COUNT_RST = 15'd256;
  localparam logic [15:0] OUT_MAX_RST        = 16'h7fff;
  localparam logic [15:0] OUT_MIN_RST        = 16'h8000;

endpackage

// ===== hdl/mcdc_ram.sv =====
// ----------------------------------------------------------------------------
// mcdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/multichannel_dc_removal_filter_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_dc_removal_filter_core
// Per-channel leaky-integrator baseline removal with start-up averaging,
// jump detection, fast recovery and output clamping.
// ----------------------------------------------------------------------------
// Usage:
//  - sample channel (sample_valid/sample_ready) takes one word: channel_index
//    and adc_sample. result channel (result_valid/result_ready) returns one
//    filtered_value word per sample, in order.
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//    settings; cfg_ready is always high. Write only while the block is idle.
//    Writing init_count restarts the shared start-up countdown.
//  - Path: an accepted sample passes the stage 1, 2 and 3 registers and the
//    output register before result_valid rises.
//  - Throughput: one sample per cycle while the result side does not stall
//    and no channel repeats within four consecutive samples. Baseline and
//    recovery counter live in one RAM (read at accept, written back from
//    stage 3); a sample whose channel is still in flight waits for its write-back.
//  - Reset: settings return to their defaults and every channel reads as
//    zero baseline and zero recovery count (per-entry valid flags), with
//    no clearing pass; a sample can be taken in the first cycle after reset.
//  - Stall: while result_valid is high and result_ready low, the whole
//    pipeline holds and sample_ready is low.
// ----------------------------------------------------------------------------
module multichannel_dc_removal_filter_core #(
  parameter int CHANNELS = mcdc_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic [mcdc_pkg::CH_W-1:0]           channel_index,
  input  logic signed [mcdc_pkg::SAMPLE_W-1:0] adc_sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [mcdc_pkg::VALUE_W-1:0] filtered_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [mcdc_pkg::CFG_W-1:0]          cfg_data
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W   = mcdc_pkg::CH_W;
  localparam int SMP_W  = mcdc_pkg::SAMPLE_W;
  localparam int BASE_W = mcdc_pkg::BASE_W;
  localparam int REC_W  = mcdc_pkg::REC_W;
  localparam int WORD_W = mcdc_pkg::WORD_W;

  // settings
  logic [31:0]        fast_beta;
  logic [31:0]        slow_beta;
  logic [4:0]         noise_shift;
  logic [30:0]        jump_level;
  logic [14:0]        recovery_count;
  logic signed [15:0] out_max;
  logic signed [15:0] out_min;
  logic [14:0]        startup_remaining;

  // pipeline control
  logic adv, accept, hazard, in_oob;
  logic [ADDR_W-1:0] in_addr;
  logic [CHANNELS-1:0] written;

  logic              s1_vld, s1_oob, s1_start, s1_init;
  logic [CH_W-1:0]   s1_ch;
  logic signed [SMP_W-1:0] s1_sample;

  logic              s2_vld, s2_oob, s2_start;
  logic [CH_W-1:0]   s2_ch;
  logic signed [SMP_W-1:0] s2_sample;
  logic [63:0]       s2_pa, s2_pb;
  logic [BASE_W-1:0] s2_avg;
  logic [REC_W-1:0]  s2_rec;

  logic              s3_vld, s3_oob, s3_start;
  logic [CH_W-1:0]   s3_ch;
  logic signed [SMP_W-1:0]  s3_sample;
  logic signed [BASE_W-1:0] s3_base;
  logic [REC_W-1:0]  s3_rec;

  logic [WORD_W-1:0] ram_rdata, ram_wdata;
  logic              ram_we;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_beta         <= mcdc_pkg::FAST_BETA_RST;
      slow_beta         <= mcdc_pkg::SLOW_BETA_RST;
      noise_shift       <= mcdc_pkg::NOISE_SHIFT_RST;
      jump_level        <= mcdc_pkg::JUMP_LEVEL_RST;
      recovery_count    <= mcdc_pkg::RECOVERY_COUNT_RST;
      out_max           <= mcdc_pkg::OUT_MAX_RST;
      out_min           <= mcdc_pkg::OUT_MIN_RST;
      startup_remaining <= mcdc_pkg::INIT_COUNT_RST;
    end else begin
      if (accept && !in_oob && startup_remaining != '0) begin
        startup_remaining <= startup_remaining - 15'd1;
      end
      if (cfg_valid) begin
        unique case (mcdc_pkg::reg_index_t'(cfg_index))
          mcdc_pkg::REG_INIT_COUNT:     startup_remaining <= cfg_data[14:0];
          mcdc_pkg::REG_FAST_BETA:      fast_beta      <= cfg_data;
          mcdc_pkg::REG_SLOW_BETA:      slow_beta      <= cfg_data;
          mcdc_pkg::REG_NOISE_SHIFT:    noise_shift    <= cfg_data[4:0];
          mcdc_pkg::REG_JUMP_LEVEL:     jump_level     <= cfg_data[30:0];
          mcdc_pkg::REG_RECOVERY_COUNT: recovery_count <= cfg_data[14:0];
          mcdc_pkg::REG_OUT_MAX:        out_max        <= cfg_data[15:0];
          mcdc_pkg::REG_OUT_MIN:        out_min        <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- accept
  assign adv     = !result_valid || result_ready;
  assign in_oob  = 32'(channel_index) >= CHANNELS;
  assign in_addr = ADDR_W'(channel_index);

  // interlock: a channel still on its way to write-back is not read again
  assign hazard = (s1_vld && !s1_oob && s1_ch == channel_index) ||
                  (s2_vld && !s2_oob && s2_ch == channel_index) ||
                  (s3_vld && !s3_oob && s3_ch == channel_index);

  assign sample_ready = adv && !hazard;
  assign accept       = sample_valid && sample_ready;

  mcdc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(s3_ch)),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  logic [BASE_W-1:0]       s1_base_u;
  logic signed [BASE_W-1:0] s1_base;
  logic [REC_W-1:0]        s1_rec;
  logic                    s1_fast;
  logic [31:0]             s1_beta, s1_alpha;
  logic signed [BASE_W:0]  s1_sum;
  logic signed [64:0]      s1_pa;
  logic signed [56:0]      s1_pb;

  always_comb begin
    s1_base_u = s1_init ? ram_rdata[BASE_W-1:0] : '0;
    s1_base   = signed'(s1_base_u);
    s1_rec    = s1_init ? ram_rdata[WORD_W-1:BASE_W] : '0;
    s1_fast   = s1_rec != '0;
    s1_beta   = s1_fast ? fast_beta : slow_beta;
    s1_alpha  = ~s1_beta + 32'd1;
    s1_sum    = (BASE_W+1)'(s1_base) + (BASE_W+1)'(s1_sample);
    s1_pa     = 65'(s1_base) * 65'(signed'({1'b0, s1_alpha}));
    s1_pb     = 57'(s1_sample) * 57'(signed'({1'b0, s1_beta}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch     <= channel_index;
      s1_sample <= adc_sample;
      s1_oob    <= in_oob;
      s1_start  <= startup_remaining != '0;
      s1_init   <= written[in_addr];
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ch     <= s1_ch;
      s2_sample <= s1_sample;
      s2_oob    <= s1_oob;
      s2_start  <= s1_start;
      s2_pa     <= s1_pa[63:0];
      s2_pb     <= 64'(s1_pb);
      s2_avg    <= s1_sum[BASE_W:1];
      s2_rec    <= (s1_fast && !s1_start) ? s1_rec - 15'd1 : s1_rec;
    end
  end

  logic [63:0] s2_acc;
  assign s2_acc = s2_pa + s2_pb;

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ch     <= s2_ch;
      s3_sample <= s2_sample;
      s3_oob    <= s2_oob;
      s3_start  <= s2_start;
      s3_base   <= s2_start ? s2_avg : s2_acc[63:32];
      s3_rec    <= s2_rec;
    end
  end

  logic signed [BASE_W:0]   s3_diff, s3_shr;
  logic signed [BASE_W+1:0] s3_val, s3_lim, s3_nlim, s3_hi, s3_lo;
  logic signed [BASE_W+1:0] s3_max, s3_min;
  logic                     s3_jump;

  always_comb begin
    s3_diff = (BASE_W+1)'(s3_sample) - (BASE_W+1)'(s3_base);
    s3_shr  = s3_diff >>> noise_shift;
    s3_lim  = signed'({3'b000, jump_level});
    s3_nlim = -s3_lim;
    s3_jump = !s3_start && ((34'(s3_shr) > s3_lim) || (34'(s3_shr) < s3_nlim));
    s3_val  = (s3_start || s3_jump) ? '0 : 34'(s3_shr);
    s3_max  = 34'(out_max);
    s3_min  = 34'(out_min);
    // upper clamp first, then lower: crossed limits give out_min
    s3_hi   = (s3_val > s3_max) ? s3_max : s3_val;
    s3_lo   = (s3_hi < s3_min) ? s3_min : s3_hi;
  end

  assign ram_we    = s3_vld && adv && !s3_oob;
  assign ram_wdata = s3_jump ? {recovery_count, BASE_W'(s3_sample)}
                             : {s3_rec, s3_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[ADDR_W'(s3_ch)] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      filtered_value <= s3_oob ? '0 : s3_lo[15:0];
    end
  end

endmodule

// ===== tb/multichannel_dc_removal_filter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_dc_removal_filter_core_tb
// Drives samples through the DC-removal filter, with random gaps on the
// sample side and random stalls on the result side. Every filtered value is
// checked against a cycle-free predictor of the baseline tracker. Settings
// are changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module multichannel_dc_removal_filter_core_tb;

  localparam int          NUM_CH      = 8;
  localparam int          PIPE_CYCLES = 8;   // settle time after the last word
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 60;

  // Predictor and store of expected filtered values
  class dc_filter_scoreboard;
    logic [14:0]        recovery_count, startup_left;
    logic [31:0]        fast_beta, slow_beta;
    logic [4:0]         noise_shift;
    logic [30:0]        jump_level;
    logic signed [15:0] out_max, out_min;
    logic signed [31:0] baseline[NUM_CH];
    logic [14:0]        recovery_left[NUM_CH];
    logic signed [15:0] expected_values[$];
    int                 errors;
    int                 checked;

    function new();
      fast_beta      = mcdc_pkg::FAST_BETA_RST;
      slow_beta      = mcdc_pkg::SLOW_BETA_RST;
      noise_shift    = mcdc_pkg::NOISE_SHIFT_RST;
      jump_level     = mcdc_pkg::JUMP_LEVEL_RST;
      recovery_count = mcdc_pkg::RECOVERY_COUNT_RST;
      out_max        = mcdc_pkg::OUT_MAX_RST;
      out_min        = mcdc_pkg::OUT_MIN_RST;
      startup_left   = mcdc_pkg::INIT_COUNT_RST;
      for (int i = 0; i < NUM_CH; i++) begin
        baseline[i]      = '0;
        recovery_left[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void apply_setting(mcdc_pkg::reg_index_t idx, logic [31:0] d);
      case (idx)
        mcdc_pkg::REG_INIT_COUNT:     startup_left   = d[14:0];
        mcdc_pkg::REG_FAST_BETA:      fast_beta      = d;
        mcdc_pkg::REG_SLOW_BETA:      slow_beta      = d;
        mcdc_pkg::REG_NOISE_SHIFT:    noise_shift    = d[4:0];
        mcdc_pkg::REG_JUMP_LEVEL:     jump_level     = d[30:0];
        mcdc_pkg::REG_RECOVERY_COUNT: recovery_count = d[14:0];
        mcdc_pkg::REG_OUT_MAX:        out_max        = d[15:0];
        mcdc_pkg::REG_OUT_MIN:        out_min        = d[15:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [2:0] ch, logic signed [23:0] s);
      logic [31:0] beta, alpha;
      logic [63:0] acc;
      longint      diff, val, lim;
      val = 0;
      if (startup_left != 0) begin
        // start-up: plain average towards the sample, output zero before the clamp
        startup_left = startup_left - 15'd1;
        baseline[ch] = 32'((longint'(baseline[ch]) + longint'(s)) >>> 1);
      end else begin
        if (recovery_left[ch] != 0) begin
          recovery_left[ch] = recovery_left[ch] - 15'd1;
          beta = fast_beta;
        end else begin
          beta = slow_beta;
        end
        alpha = 32'd0 - beta;
        acc = {{32{baseline[ch][31]}}, baseline[ch]} * {32'd0, alpha}
            + {{40{s[23]}}, s} * {32'd0, beta};
        baseline[ch] = acc[63:32];
        diff = longint'(s) - longint'(baseline[ch]);
        val  = diff >>> noise_shift;
        lim  = longint'(jump_level);
        if (val > lim || val < -lim) begin
          // jump: snap to the sample and rearm fast recovery
          recovery_left[ch] = recovery_count;
          baseline[ch]      = 32'(s);
          val               = 0;
        end
      end
      // upper clamp first, so crossed limits give out_min
      if (val > longint'(out_max)) val = longint'(out_max);
      if (val < longint'(out_min)) val = longint'(out_min);
      expected_values.push_back(16'(val));
    endfunction

    function void check_value(logic signed [15:0] v);
      logic signed [15:0] want;
      if (expected_values.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected filtered_value word: expected none, actual %0d", $time, v);
      end else begin
        want = expected_values.pop_front();
        checked++;
        if (v !== want) begin
          errors++;
          if (errors <= 50)
            $display("%0t: filtered_value mismatch: expected %0d, actual %0d",
                     $time, want, v);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  logic [2:0]         channel_index = '0;
  logic signed [23:0] adc_sample = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [15:0] filtered_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  dc_filter_scoreboard sb = new();

  int unsigned        cycle_count = 0;
  int                 samples_sent = 0;
  int                 sink_wait = 0;
  int                 sink_draw;
  bit                 fast_src = 1'b0;
  bit                 fast_sink = 1'b0;
  logic signed [23:0] dc_level[NUM_CH];
  logic [2:0]         cur_ch = '0;

  multichannel_dc_removal_filter_core u_top (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .channel_index  (channel_index),
    .adc_sample     (adc_sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .filtered_value (filtered_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // watch both channels; the result word is never the one taken this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_value(filtered_value);
      if (sample_valid && sample_ready) begin
        sb.note_sample(channel_index, adc_sample);
        samples_sent++;
      end
    end
  end

  // result side: random stall after each word, with runs of no stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      sink_wait    <= 0;
    end else if (result_valid && result_ready) begin
      if ($urandom_range(0, 39) == 0) fast_sink = !fast_sink;
      sink_draw = fast_sink ? 0 : $urandom_range(0, 9);
      sink_wait    <= sink_draw;
      result_ready <= (sink_draw == 0);
    end else if (sink_wait > 0) begin
      sink_wait    <= sink_wait - 1;
      result_ready <= (sink_wait == 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [2:0] ch, input logic signed [23:0] s);
    int gap;
    if ($urandom_range(0, 39) == 0) fast_src = !fast_src;
    gap = fast_src ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid  <= 1'b1;
    channel_index <= ch;
    adc_sample    <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic write_setting(input mcdc_pkg::reg_index_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_setting(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let every expected word come back, then let the pipeline go quiet;
  // wait for the next edge first so the last accepted word is already noted
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_values.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // junk above the register width must be dropped by the core
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    return (w >= 32) ? v : (v | ($urandom << w));
  endfunction

  function automatic logic signed [23:0] pick_sample(logic [2:0] ch);
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      2: return dc_level[ch] + 24'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return dc_level[ch] + 24'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic logic [31:0] pick_beta(bit fast);
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return 32'hffffffff;
      2: return $urandom;
      3: return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1 << $urandom_range(0, 31);
      default: return 32'd1 << (fast ? $urandom_range(22, 30) : $urandom_range(12, 24));
    endcase
  endfunction

  task automatic random_settings();
    logic [15:0] a, b, t;
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = $urandom_range(1, 8);
      2: v = $urandom_range(9, 40);
      default: v = $urandom_range(0, 15) == 0 ? 32767 : $urandom_range(0, 3);
    endcase
    write_setting(mcdc_pkg::REG_INIT_COUNT, with_junk(v, 15));
    write_setting(mcdc_pkg::REG_FAST_BETA, pick_beta(1'b1));
    write_setting(mcdc_pkg::REG_SLOW_BETA, pick_beta(1'b0));
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 31;
      default: v = $urandom_range(0, 8);
    endcase
    write_setting(mcdc_pkg::REG_NOISE_SHIFT, with_junk(v, 5));
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = $urandom_range(1, 64);
      2: v = 32'h7fffffff;
      3: v = $urandom;
      default: v = $urandom_range(100, 40000);
    endcase
    write_setting(mcdc_pkg::REG_JUMP_LEVEL, with_junk(v, 31));
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 32767;
      2: v = $urandom;
      default: v = $urandom_range(1, 20);
    endcase
    write_setting(mcdc_pkg::REG_RECOVERY_COUNT, with_junk(v, 15));
    a = 16'h7fff;
    b = 16'h8000;
    case ($urandom_range(0, 4))
      0: begin
        a = 16'($urandom);
        b = 16'($urandom);
        if ($signed(a) < $signed(b)) begin
          t = a;
          a = b;
          b = t;
        end
      end
      1: begin
        // crossed limits
        a = 16'($urandom_range(0, 2000)) - 16'd1000;
        b = a + 16'($urandom_range(1, 500));
      end
      2: begin
        a = 16'h8000;
        b = 16'h7fff;
      end
      default: ;
    endcase
    write_setting(mcdc_pkg::REG_OUT_MAX, with_junk({16'd0, a}, 16));
    write_setting(mcdc_pkg::REG_OUT_MIN, with_junk({16'd0, b}, 16));
  endtask

  initial begin
    for (int i = 0; i < NUM_CH; i++) dc_level[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 16 start-up words, then one filtered word
    for (int i = 0; i < 17; i++) begin
      case (i % 4)
        0: send_sample(3'd0, 24'sh7fffff);
        1: send_sample(3'd7, 24'sh800000);
        2: send_sample(3'(i), -24'sd1);
        default: send_sample(3'(i), 24'sd0);
      endcase
    end
    drain();

    // longest start-up, other settings at one extreme
    write_setting(mcdc_pkg::REG_INIT_COUNT, 32'd32767);
    write_setting(mcdc_pkg::REG_FAST_BETA, 32'd0);
    write_setting(mcdc_pkg::REG_SLOW_BETA, 32'hffffffff);
    write_setting(mcdc_pkg::REG_NOISE_SHIFT, 32'd0);
    write_setting(mcdc_pkg::REG_JUMP_LEVEL, 32'h7fffffff);
    write_setting(mcdc_pkg::REG_RECOVERY_COUNT, 32'd32767);
    send_sample(3'd3, 24'sh800000);
    send_sample(3'd3, 24'sh800001);
    send_sample(3'd4, 24'sh7fffff);
    drain();

    // filtering straight away; zero jump level, zero recovery count after a snap,
    // full shift and crossed limits
    write_setting(mcdc_pkg::REG_INIT_COUNT, 32'd0);
    write_setting(mcdc_pkg::REG_FAST_BETA, 32'd0);
    write_setting(mcdc_pkg::REG_SLOW_BETA, 32'd1);
    write_setting(mcdc_pkg::REG_NOISE_SHIFT, 32'd31);
    write_setting(mcdc_pkg::REG_JUMP_LEVEL, 32'd0);
    write_setting(mcdc_pkg::REG_RECOVERY_COUNT, 32'd0);
    write_setting(mcdc_pkg::REG_OUT_MAX, 32'hffff_fffb);
    write_setting(mcdc_pkg::REG_OUT_MIN, 32'h0000_0005);
    send_sample(3'd0, 24'sh7fffff);
    send_sample(3'd0, 24'sh800000);
    send_sample(3'd7, 24'sd0);
    send_sample(3'd3, 24'sh7fffff);
    send_sample(3'd3, 24'sh7fffff);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_settings();
      for (int i = 0; i < NUM_CH; i++) dc_level[i] = 24'(int'($urandom_range(0, 4000000)) - 2000000);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // runs on one channel exercise the write-back hazard
        if ($urandom_range(0, 4) != 0) cur_ch = 3'($urandom_range(0, NUM_CH - 1));
        send_sample(cur_ch, pick_sample(cur_ch));
      end
      drain();
    end

    $display("Covered %0d samples over %0d settings phases; %0d filtered values checked.",
             samples_sent, RAND_PHASES + 3, sb.checked);
    $display("Mismatches or stray words: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mcdc_pkg.sv
hdl/mcdc_ram.sv
hdl/multichannel_dc_removal_filter_core.sv
tb/multichannel_dc_removal_filter_core_tb.sv
